// ----- hdl/assert_macros.svh -----
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with an active-low reset that disables it.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property that must hold while the result queue shows an item.
`define ASSERT_SHOWN(label, clk, rst_n, shown, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (shown) |-> (prop)) \
        else $error(msg);

`endif

// ----- hdl/nps_pkg.sv -----
// Package with types, codes and constants of the PRM sentence parser.
`default_nettype none
package nps_pkg;

    localparam int VALUE_BITS_DEF  = 16;
    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int OUT_BITS        = 16;

    localparam logic [3:0] CL_OTHER = 4'd0;
    localparam logic [3:0] CL_COMMA = 4'd1;
    localparam logic [3:0] CL_STAR  = 4'd2;
    localparam logic [3:0] CL_DOT   = 4'd3;
    localparam logic [3:0] CL_DIGIT = 4'd4;
    localparam logic [3:0] CL_S     = 4'd5;
    localparam logic [3:0] CL_E     = 4'd6;
    localparam logic [3:0] CL_A     = 4'd7;
    localparam logic [3:0] CL_V     = 4'd8;
    localparam logic [3:0] CL_P     = 4'd9;
    localparam logic [3:0] CL_R     = 4'd10;
    localparam logic [3:0] CL_M     = 4'd11;

    localparam logic [2:0] F_HEADER = 3'd0;
    localparam logic [2:0] F_SOURCE = 3'd1;
    localparam logic [2:0] F_SHAFT  = 3'd2;
    localparam logic [2:0] F_SPEED  = 3'd3;
    localparam logic [2:0] F_PITCH  = 3'd4;
    localparam logic [2:0] F_STATUS = 3'd5;
    localparam logic [2:0] F_DONE   = 3'd6;

    localparam logic [2:0] E_NONE   = 3'd0;
    localparam logic [2:0] E_HEADER = 3'd1;
    localparam logic [2:0] E_SOURCE = 3'd2;
    localparam logic [2:0] E_STATUS = 3'd6;

    localparam logic [1:0] ST_NONE  = 2'd0;
    localparam logic [1:0] ST_A     = 2'd1;
    localparam logic [1:0] ST_V     = 2'd2;
    localparam logic [1:0] ST_OTHER = 2'd3;

    localparam logic [2:0] CNT_MAX  = 3'd7;

    typedef struct packed {
        logic [3:0] cls;
        logic [3:0] digit;
        logic       last;
    } t_token;

    typedef struct packed {
        logic [2:0]          error_code;
        logic                source_is_e;
        logic [OUT_BITS-1:0] shaft_value;
        logic [OUT_BITS-1:0] speed_value;
        logic [OUT_BITS-1:0] pitch_value;
        logic                status_void;
    } t_result;

    localparam int TOKEN_W  = $bits(t_token);
    localparam int RESULT_W = $bits(t_result);

endpackage
`default_nettype wire

// ----- hdl/nmea_prm_sentence_parser.sv -----
// Streaming checker for PRM engine sentences, one byte per item, one result per sentence.
// The block accepts one byte per clock cycle, sustained: each byte is classified on
// entry and written to a short token queue, and the field parser takes one token per
// cycle and updates its state in that cycle, the multiply-by-ten accumulate being the
// deepest path. The result of a sentence enters the result queue at the edge where the
// parser takes the last byte from the token queue, so it shows at the output only after
// that byte has passed through the token queue. Input stalls only when the result queue
// is full and the parser waits on a last byte, which backs up the token queue.
`default_nettype none
module nmea_prm_sentence_parser
    import nps_pkg::*;
#(
    parameter int VALUE_BITS  = VALUE_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                push,
    output logic                     full,
    input  wire logic [7:0]          i_char_byte,
    input  wire logic                i_end_of_sentence,
    output logic                     empty,
    input  wire logic                pop,
    output logic [2:0]               o_error_code,
    output logic                     o_source_is_e,
    output logic [OUT_BITS-1:0]      o_shaft_value,
    output logic [OUT_BITS-1:0]      o_speed_value,
    output logic [OUT_BITS-1:0]      o_pitch_value,
    output logic                     o_status_void
);

    t_token  w_in_tok;
    t_token  w_q_tok;
    t_result w_res;
    t_result w_out_res;
    logic    w_tok_empty;
    logic    w_tok_pop;
    logic    w_res_full;
    logic    w_res_push;
    logic [TOKEN_W-1:0]  w_q_tok_bits;
    logic [RESULT_W-1:0] w_out_bits;

    nps_classify u_classify (
        .i_char_byte       (i_char_byte),
        .i_end_of_sentence (i_end_of_sentence),
        .o_token           (w_in_tok)
    );

    nps_fifo #(
        .WIDTH (TOKEN_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_tok_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .i_data  (w_in_tok),
        .i_pop   (w_tok_pop),
        .o_empty (w_tok_empty),
        .o_data  (w_q_tok_bits)
    );

    assign w_q_tok = t_token'(w_q_tok_bits);

    nps_parse #(
        .VALUE_BITS (VALUE_BITS)
    ) u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_empty (w_tok_empty),
        .i_tok       (w_q_tok),
        .o_tok_pop   (w_tok_pop),
        .i_res_full  (w_res_full),
        .o_res_push  (w_res_push),
        .o_res       (w_res)
    );

    nps_fifo #(
        .WIDTH (RESULT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .o_full  (w_res_full),
        .i_data  (w_res),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (w_out_bits)
    );

    assign w_out_res     = t_result'(w_out_bits);
    assign o_error_code  = w_out_res.error_code;
    assign o_source_is_e = w_out_res.source_is_e;
    assign o_shaft_value = w_out_res.shaft_value;
    assign o_speed_value = w_out_res.speed_value;
    assign o_pitch_value = w_out_res.pitch_value;
    assign o_status_void = w_out_res.status_void;

endmodule
`default_nettype wire

// ----- hdl/nps_fifo.sv -----
// Small first-in first-out queue of packed items.
`default_nettype none
module nps_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    output logic                  o_full,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic                  o_empty,
    output logic      [WIDTH-1:0] o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, r_rd;
    logic [AW:0]      r_count, n_count;
    logic             w_do_push, w_do_pop;

    assign o_full    = (r_count == (AW+1)'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_data    = r_mem[r_rd];

    always_comb begin
        n_count = r_count;
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_do_pop && !w_do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/nps_classify.sv -----
// Front end: sorts each incoming byte into a character class.
`default_nettype none
module nps_classify
    import nps_pkg::*;
(
    input  wire logic [7:0] i_char_byte,
    input  wire logic       i_end_of_sentence,
    output t_token          o_token
);

    always_comb begin
        o_token.last  = i_end_of_sentence;
        o_token.digit = i_char_byte[3:0];
        case (i_char_byte)
            8'h2C:   o_token.cls = CL_COMMA;
            8'h2A:   o_token.cls = CL_STAR;
            8'h2E:   o_token.cls = CL_DOT;
            8'h53:   o_token.cls = CL_S;
            8'h45:   o_token.cls = CL_E;
            8'h41:   o_token.cls = CL_A;
            8'h56:   o_token.cls = CL_V;
            8'h50:   o_token.cls = CL_P;
            8'h52:   o_token.cls = CL_R;
            8'h4D:   o_token.cls = CL_M;
            default: begin
                if (i_char_byte inside {[8'h30:8'h39]}) begin
                    o_token.cls = CL_DIGIT;
                end else begin
                    o_token.cls = CL_OTHER;
                end
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- hdl/nps_parse.sv -----
// Back end: field state machine that checks the sentence and builds the result.
`default_nettype none
module nps_parse
    import nps_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_tok_empty,
    input  wire t_token i_tok,
    output logic        o_tok_pop,
    input  wire logic   i_res_full,
    output logic        o_res_push,
    output t_result     o_res
);

    function automatic logic f_close_ok(input logic [2:0] field, input logic [2:0] cnt,
                                        input logic hdr, input logic dig,
                                        input logic [1:0] status);
        logic ok;
        case (field)
            F_HEADER:                  ok = (cnt == 3'd6) && hdr;
            F_SOURCE:                  ok = (cnt == 3'd1);
            F_SHAFT, F_SPEED, F_PITCH: ok = dig;
            default:                   ok = (cnt == 3'd1) &&
                                            (status == ST_A || status == ST_V);
        endcase
        return ok;
    endfunction

    logic [2:0]            r_field, n_field;
    logic [2:0]            r_cnt, n_cnt;
    logic                  r_hdr, n_hdr;
    logic [VALUE_BITS-1:0] r_acc, n_acc;
    logic                  r_dot, n_dot;
    logic                  r_dig, n_dig;
    logic [2:0]            r_err, n_err;
    logic                  r_src, n_src;
    logic [OUT_BITS-1:0]   r_shaft, n_shaft;
    logic [OUT_BITS-1:0]   r_speed, n_speed;
    logic [OUT_BITS-1:0]   r_pitch, n_pitch;
    logic [1:0]            r_status, n_status;

    logic [VALUE_BITS+3:0] w_wide;
    logic [VALUE_BITS+3:0] w_sum;
    logic                  w_consume;
    logic                  w_close;
    logic                  w_ok;
    logic [2:0]            w_reached;

    assign w_wide    = {4'b0000, r_acc};
    assign w_sum     = (w_wide << 3) + (w_wide << 1) + (VALUE_BITS+4)'(i_tok.digit);
    assign w_consume = !i_tok_empty && (!i_tok.last || !i_res_full);
    assign o_tok_pop  = w_consume;
    assign o_res_push = w_consume && i_tok.last;

    always_comb begin
        n_field  = r_field;
        n_cnt    = r_cnt;
        n_hdr    = r_hdr;
        n_acc    = r_acc;
        n_dot    = r_dot;
        n_dig    = r_dig;
        n_err    = r_err;
        n_src    = r_src;
        n_shaft  = r_shaft;
        n_speed  = r_speed;
        n_pitch  = r_pitch;
        n_status = r_status;
        w_close  = 1'b0;
        w_ok     = 1'b0;
        w_reached = F_DONE;
        o_res    = '0;

        if (r_err == E_NONE && r_field <= F_STATUS) begin
            w_close = (r_field < F_STATUS && i_tok.cls == CL_COMMA) ||
                      (r_field == F_STATUS && i_tok.cls == CL_STAR);
            if (w_close) begin
                w_ok = f_close_ok(r_field, r_cnt, r_hdr, r_dig, r_status);
                if (w_ok) begin
                    case (r_field)
                        F_SHAFT: n_shaft = OUT_BITS'(r_acc);
                        F_SPEED: n_speed = OUT_BITS'(r_acc);
                        F_PITCH: n_pitch = OUT_BITS'(r_acc);
                        default: ;
                    endcase
                    n_field = r_field + 3'd1;
                    n_cnt   = '0;
                    n_acc   = '0;
                    n_dot   = 1'b0;
                    n_dig   = 1'b0;
                end else begin
                    n_err = r_field + 3'd1;
                end
            end else begin
                if (r_cnt != CNT_MAX) begin
                    n_cnt = r_cnt + 3'd1;
                end
                case (r_field)
                    F_HEADER: begin
                        if ((r_cnt == 3'd3 && i_tok.cls != CL_P) ||
                            (r_cnt == 3'd4 && i_tok.cls != CL_R) ||
                            (r_cnt == 3'd5 && i_tok.cls != CL_M)) begin
                            n_hdr = 1'b0;
                        end
                    end
                    F_SOURCE: begin
                        if (i_tok.cls == CL_S) begin
                            n_src = 1'b0;
                        end else if (i_tok.cls == CL_E) begin
                            n_src = 1'b1;
                        end else begin
                            n_err = E_SOURCE;
                        end
                    end
                    F_SHAFT, F_SPEED, F_PITCH: begin
                        if (i_tok.cls == CL_DIGIT) begin
                            n_dig = 1'b1;
                            if (!r_dot) begin
                                if (w_sum[VALUE_BITS+3:VALUE_BITS] != 4'd0) begin
                                    n_acc = '1;
                                end else begin
                                    n_acc = w_sum[VALUE_BITS-1:0];
                                end
                            end
                        end else if (i_tok.cls == CL_DOT) begin
                            n_dot = 1'b1;
                        end else begin
                            n_err = r_field + 3'd1;
                        end
                    end
                    default: begin
                        if (r_cnt == 3'd0) begin
                            if (i_tok.cls == CL_A) begin
                                n_status = ST_A;
                            end else if (i_tok.cls == CL_V) begin
                                n_status = ST_V;
                            end else begin
                                n_status = ST_OTHER;
                            end
                        end
                    end
                endcase
            end
        end

        if (i_tok.last) begin
            if (n_err == E_NONE && n_field <= F_STATUS) begin
                if (f_close_ok(n_field, n_cnt, n_hdr, n_dig, n_status)) begin
                    case (n_field)
                        F_SHAFT: n_shaft = OUT_BITS'(n_acc);
                        F_SPEED: n_speed = OUT_BITS'(n_acc);
                        F_PITCH: n_pitch = OUT_BITS'(n_acc);
                        default: ;
                    endcase
                    n_field = n_field + 3'd1;
                    if (n_field <= F_STATUS) begin
                        n_err = n_field + 3'd1;
                    end
                end else begin
                    n_err = n_field + 3'd1;
                end
            end

            w_reached          = (n_err == E_NONE) ? F_DONE : n_err - 3'd1;
            o_res.error_code   = n_err;
            o_res.source_is_e  = (w_reached > F_SOURCE) ? n_src : 1'b0;
            o_res.shaft_value  = (w_reached > F_SHAFT) ? n_shaft : '0;
            o_res.speed_value  = (w_reached > F_SPEED) ? n_speed : '0;
            o_res.pitch_value  = (w_reached > F_PITCH) ? n_pitch : '0;
            o_res.status_void  = (n_err == E_NONE) && (n_status == ST_V);

            n_field  = F_HEADER;
            n_cnt    = '0;
            n_hdr    = 1'b1;
            n_acc    = '0;
            n_dot    = 1'b0;
            n_dig    = 1'b0;
            n_err    = E_NONE;
            n_src    = 1'b0;
            n_shaft  = '0;
            n_speed  = '0;
            n_pitch  = '0;
            n_status = ST_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field  <= F_HEADER;
            r_cnt    <= '0;
            r_hdr    <= 1'b1;
            r_acc    <= '0;
            r_dot    <= 1'b0;
            r_dig    <= 1'b0;
            r_err    <= E_NONE;
            r_src    <= 1'b0;
            r_shaft  <= '0;
            r_speed  <= '0;
            r_pitch  <= '0;
            r_status <= ST_NONE;
        end else if (w_consume) begin
            r_field  <= n_field;
            r_cnt    <= n_cnt;
            r_hdr    <= n_hdr;
            r_acc    <= n_acc;
            r_dot    <= n_dot;
            r_dig    <= n_dig;
            r_err    <= n_err;
            r_src    <= n_src;
            r_shaft  <= n_shaft;
            r_speed  <= n_speed;
            r_pitch  <= n_pitch;
            r_status <= n_status;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/nps_checker.sv -----
// Port-level assertions for the PRM sentence parser and the bind that attaches them.
`default_nettype none
`include "assert_macros.svh"
module nps_checker
    import nps_pkg::*;
(
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_empty,
    input wire logic                i_pop,
    input wire logic [2:0]          i_error_code,
    input wire logic                i_source_is_e,
    input wire logic [OUT_BITS-1:0] i_shaft_value,
    input wire logic [OUT_BITS-1:0] i_pitch_value,
    input wire logic                i_status_void
);

    `ASSERT_SHOWN(a_code_range, i_clk, i_rst_n, !i_empty, i_error_code <= E_STATUS, "error code out of range")
    `ASSERT_SHOWN(a_void_only_ok, i_clk, i_rst_n, !i_empty && i_error_code != E_NONE, !i_status_void, "status flag set on a failed sentence")
    `ASSERT_SHOWN(a_early_zero, i_clk, i_rst_n, !i_empty && (i_error_code == E_HEADER || i_error_code == E_SOURCE), !i_source_is_e && i_shaft_value == '0, "unparsed fields not zero")
    `ASSERT_CLK(a_hold, i_clk, i_rst_n, (!i_empty && !i_pop) |=> (!i_empty && $stable(i_error_code) && $stable(i_pitch_value)), "waiting item changed")

endmodule

bind nmea_prm_sentence_parser nps_checker u_nps_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_empty       (empty),
    .i_pop         (pop),
    .i_error_code  (o_error_code),
    .i_source_is_e (o_source_is_e),
    .i_shaft_value (o_shaft_value),
    .i_pitch_value (o_pitch_value),
    .i_status_void (o_status_void)
);
`default_nettype wire

// ----- bench/nmea_prm_sentence_parser_chk.sv -----
// Checker for the PRM sentence parser: predicts each sentence result and compares it.
module nmea_prm_sentence_parser_chk
    import nps_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  wire logic                i_full,
    input  wire logic [7:0]          i_char_byte,
    input  wire logic                i_end_of_sentence,
    input  wire logic                i_empty,
    input  wire logic                i_pop,
    input  wire logic [2:0]          i_error_code,
    input  wire logic                i_source_is_e,
    input  wire logic [OUT_BITS-1:0] i_shaft_value,
    input  wire logic [OUT_BITS-1:0] i_speed_value,
    input  wire logic [OUT_BITS-1:0] i_pitch_value,
    input  wire logic                i_status_void,
    output int                       o_fail_count,
    output int                       o_pending
);

    localparam int unsigned VALUE_MAX  = 32'h0000_FFFF;
    localparam logic [2:0]  HEADER_LEN = 3'd6;

    logic [2:0]          field_sel;
    logic [2:0]          field_len;
    logic [2:0]          first_err;
    logic                header_ok;
    logic                dot_found;
    logic                digit_found;
    logic                src_e;
    logic [1:0]          status_seen;
    logic [OUT_BITS-1:0] number_acc;
    logic [OUT_BITS-1:0] shaft_held;
    logic [OUT_BITS-1:0] speed_held;
    logic [OUT_BITS-1:0] pitch_held;
    t_result             results_due[$];
    int                  n_fail = 0;

    task automatic clear_field();
        field_len   = '0;
        number_acc  = '0;
        dot_found   = 1'b0;
        digit_found = 1'b0;
    endtask

    task automatic start_sentence();
        field_sel   = F_HEADER;
        header_ok   = 1'b1;
        first_err   = E_NONE;
        src_e       = 1'b0;
        shaft_held  = '0;
        speed_held  = '0;
        pitch_held  = '0;
        status_seen = ST_NONE;
        clear_field();
    endtask

    task automatic add_to_field(input logic [7:0] c);
        logic [2:0]  pos;
        int unsigned sum;
        pos = field_len;
        if (field_len < CNT_MAX) begin
            field_len = field_len + 3'd1;
        end
        case (field_sel)
            F_HEADER: begin
                if ((pos == 3'd3 && c != "P") || (pos == 3'd4 && c != "R") ||
                    (pos == 3'd5 && c != "M")) begin
                    header_ok = 1'b0;
                end
            end
            F_SOURCE: begin
                if (c == "S") begin
                    src_e = 1'b0;
                end else if (c == "E") begin
                    src_e = 1'b1;
                end else begin
                    first_err = E_SOURCE;
                end
            end
            F_SHAFT, F_SPEED, F_PITCH: begin
                if (c >= "0" && c <= "9") begin
                    digit_found = 1'b1;
                    if (!dot_found) begin
                        sum = number_acc * 10 + c - "0";
                        number_acc = (sum > VALUE_MAX) ? VALUE_MAX[OUT_BITS-1:0] :
                                                         sum[OUT_BITS-1:0];
                    end
                end else if (c == ".") begin
                    dot_found = 1'b1;
                end else begin
                    first_err = field_sel + 3'd1;
                end
            end
            default: begin
                if (pos == 3'd0) begin
                    status_seen = (c == "A") ? ST_A : (c == "V") ? ST_V : ST_OTHER;
                end
            end
        endcase
    endtask

    task automatic close_field();
        logic ok;
        case (field_sel)
            F_HEADER: ok = (field_len == HEADER_LEN) && header_ok;
            F_SOURCE: ok = (field_len == 3'd1);
            F_SHAFT: begin
                ok = digit_found;
                if (ok) shaft_held = number_acc;
            end
            F_SPEED: begin
                ok = digit_found;
                if (ok) speed_held = number_acc;
            end
            F_PITCH: begin
                ok = digit_found;
                if (ok) pitch_held = number_acc;
            end
            default: ok = (field_len == 3'd1) && (status_seen == ST_A || status_seen == ST_V);
        endcase
        if (ok) begin
            field_sel = field_sel + 3'd1;
            clear_field();
        end else begin
            first_err = field_sel + 3'd1;
        end
    endtask

    task automatic parse_byte(input logic [7:0] c, input logic last);
        logic [2:0] reached;
        t_result    res;
        if (first_err == E_NONE && field_sel <= F_STATUS) begin
            if (field_sel < F_STATUS && c == ",") begin
                close_field();
            end else if (field_sel == F_STATUS && c == "*") begin
                close_field();
            end else begin
                add_to_field(c);
            end
        end
        if (last) begin
            if (first_err == E_NONE && field_sel <= F_STATUS) begin
                close_field();
                if (first_err == E_NONE && field_sel <= F_STATUS) begin
                    first_err = field_sel + 3'd1;
                end
            end
            reached = (first_err == E_NONE) ? F_DONE : first_err - 3'd1;
            res.error_code  = first_err;
            res.source_is_e = (reached > F_SOURCE) ? src_e : 1'b0;
            res.shaft_value = (reached > F_SHAFT) ? shaft_held : '0;
            res.speed_value = (reached > F_SPEED) ? speed_held : '0;
            res.pitch_value = (reached > F_PITCH) ? pitch_held : '0;
            res.status_void = (first_err == E_NONE) && (status_seen == ST_V);
            results_due.push_back(res);
            start_sentence();
        end
    endtask

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_fail++;
        end
    endtask

    initial begin
        start_sentence();
        o_fail_count = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin
        t_result due;
        if (i_rst_n) begin
            if (i_push && !i_full) begin
                parse_byte(i_char_byte, i_end_of_sentence);
            end
            if (i_pop && !i_empty) begin
                if (results_due.size() == 0) begin
                    $error("result item with no sentence waiting for one");
                    n_fail++;
                end else begin
                    due = results_due.pop_front();
                    check_field("error_code", due.error_code, i_error_code);
                    check_field("source_is_e", due.source_is_e, i_source_is_e);
                    check_field("shaft_value", due.shaft_value, i_shaft_value);
                    check_field("speed_value", due.speed_value, i_speed_value);
                    check_field("pitch_value", due.pitch_value, i_pitch_value);
                    check_field("status_void", due.status_void, i_status_void);
                end
            end
        end
        o_fail_count <= n_fail;
        o_pending    <= results_due.size();
    end

endmodule

// ----- bench/nmea_prm_sentence_parser_tb.sv -----
// Testbench top for the PRM sentence parser: sentence stimulus, watchdog and verdict.
module nmea_prm_sentence_parser_tb;
    import nps_pkg::*;

    localparam int STALL_LIMIT   = 4000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int BYTE_TARGET   = 1150;
    localparam int CALM_START    = 500;
    localparam int CALM_END      = 850;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                push;
    logic                full;
    logic [7:0]          char_byte;
    logic                end_of_sentence;
    logic                empty;
    logic                pop;
    logic [2:0]          error_code;
    logic                source_is_e;
    logic [OUT_BITS-1:0] shaft_value;
    logic [OUT_BITS-1:0] speed_value;
    logic [OUT_BITS-1:0] pitch_value;
    logic                status_void;
    logic                calm;
    int                  fail_count;
    int                  pending;
    int                  stall_cycles = 0;
    int                  bytes_sent = 0;
    logic [7:0]          sentence_q[$];

    always #1 i_clk = ~i_clk;

    nmea_prm_sentence_parser u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_char_byte      (char_byte),
        .i_end_of_sentence(end_of_sentence),
        .empty            (empty),
        .pop              (pop),
        .o_error_code     (error_code),
        .o_source_is_e    (source_is_e),
        .o_shaft_value    (shaft_value),
        .o_speed_value    (speed_value),
        .o_pitch_value    (pitch_value),
        .o_status_void    (status_void)
    );

    nmea_prm_sentence_parser_chk u_chk (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (push),
        .i_full           (full),
        .i_char_byte      (char_byte),
        .i_end_of_sentence(end_of_sentence),
        .i_empty          (empty),
        .i_pop            (pop),
        .i_error_code     (error_code),
        .i_source_is_e    (source_is_e),
        .i_shaft_value    (shaft_value),
        .i_speed_value    (speed_value),
        .i_pitch_value    (pitch_value),
        .i_status_void    (status_void),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    always @(posedge i_clk) begin
        pop <= i_rst_n && (calm || $urandom_range(0, 99) >= 22);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("nmea_prm_sentence_parser: mismatch");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic add_str(input string s);
        for (int i = 0; i < s.len(); i++) begin
            sentence_q.push_back(s[i]);
        end
    endtask

    task automatic add_number();
        int kind;
        int n;
        kind = $urandom_range(0, 9);
        n = (kind == 0) ? $urandom_range(5, 7) : $urandom_range(1, 4);
        if (kind == 1) begin
            add_str(".");
        end
        repeat (n) sentence_q.push_back(8'("0" + $urandom_range(0, 9)));
        if ($urandom_range(0, 2) == 0) begin
            add_str(".");
            repeat ($urandom_range(0, 2)) sentence_q.push_back(8'("0" + $urandom_range(0, 9)));
        end
    endtask

    // The last byte of the queue carries the end-of-sentence mark.
    task automatic send_sentence();
        for (int i = 0; i < sentence_q.size(); i++) begin
            if (!calm) begin
                while ($urandom_range(0, 99) < 22) begin
                    push <= 1'b0;
                    @(posedge i_clk);
                end
            end
            push            <= 1'b1;
            char_byte       <= sentence_q[i];
            end_of_sentence <= (i == sentence_q.size() - 1);
            do @(posedge i_clk); while (full);
            bytes_sent++;
        end
        sentence_q.delete();
    endtask

    task automatic build_random_sentence();
        string      hex = "0123456789ABCDEF";
        int         kind;
        int         p;
        logic [7:0] b;
        kind = $urandom_range(0, 99);
        if (kind < 8) begin
            repeat ($urandom_range(1, 10)) begin
                b = ($urandom_range(0, 3) == 0) ? "," : 8'($urandom_range(0, 255));
                sentence_q.push_back(b);
            end
        end else begin
            if ($urandom_range(0, 9) == 0) begin
                repeat (3) sentence_q.push_back(8'($urandom_range(33, 126)));
            end else begin
                add_str("$");
                repeat (2) sentence_q.push_back(8'("A" + $urandom_range(0, 25)));
            end
            add_str("PRM,");
            add_str($urandom_range(0, 1) ? "S," : "E,");
            add_number();
            add_str(",");
            add_number();
            add_str(",");
            add_number();
            add_str($urandom_range(0, 1) ? ",A" : ",V");
            case ($urandom_range(0, 3))
                0: ;
                1: add_str("*");
                default: begin
                    add_str("*");
                    sentence_q.push_back(hex[$urandom_range(0, 15)]);
                    sentence_q.push_back(hex[$urandom_range(0, 15)]);
                    if ($urandom_range(0, 1)) add_str("\r\n");
                end
            endcase
            if (kind >= 70) begin
                p = $urandom_range(0, sentence_q.size() - 1);
                case ($urandom_range(0, 3))
                    0: sentence_q[p] = 8'($urandom_range(0, 255));
                    1: sentence_q.delete(p);
                    2: begin
                        case ($urandom_range(0, 3))
                            0: b = ",";
                            1: b = "*";
                            2: b = ".";
                            default: b = 8'($urandom_range(0, 255));
                        endcase
                        sentence_q.insert(p, b);
                    end
                    default: begin
                        while (sentence_q.size() > p + 1) void'(sentence_q.pop_back());
                    end
                endcase
            end
        end
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        push            <= 1'b0;
        char_byte       <= 8'h00;
        end_of_sentence <= 1'b0;
        pop             <= 1'b0;
        calm            <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        add_str("$IIPRM,S,12.5,1500,3.2,A*3F\r\n");
        send_sentence();
        add_str("$XXPRM,E,65535,99999,0,V");
        send_sentence();
        add_str("$IIPRM,S,.5,007.,1.2.3,A*");
        send_sentence();
        add_str("$IIPRX,S,1,2,3,A");
        send_sentence();
        add_str("$IPRM,S,1,2,3,A");
        send_sentence();
        add_str("$IIPRM,X,1,2,3,A");
        send_sentence();
        add_str("$IIPRM,SE,1,2,3,A");
        send_sentence();
        add_str("$IIPRM,,1,2,3,A");
        send_sentence();
        add_str("$IIPRM,E,1a,2,3,A");
        send_sentence();
        add_str("$IIPRM,E,12,..,3,A");
        send_sentence();
        add_str("$IIPRM,S,1,2,,A");
        send_sentence();
        add_str("$IIPRM,S,1,2,3,AV*00");
        send_sentence();
        add_str("$IIPRM,S,1,2,3,A,B");
        send_sentence();
        add_str("$IIPRM,S,1,2,3,X");
        send_sentence();
        add_str("$IIPRM,S,1,2,3,*");
        send_sentence();
        add_str("$IIPRM,S,1,2,");
        send_sentence();
        add_str("$IIPRM,S,4");
        send_sentence();
        add_str("$II");
        send_sentence();
        add_str(",");
        send_sentence();
        sentence_q.push_back(8'hFF);
        add_str("IIPRM,E,7,8,9,V*");
        sentence_q.push_back(8'h00);
        send_sentence();
        add_str("$IIPRM,S,");
        sentence_q.push_back(8'hB1);
        send_sentence();

        while (bytes_sent < BYTE_TARGET) begin
            calm <= (bytes_sent >= CALM_START && bytes_sent < CALM_END);
            build_random_sentence();
            send_sentence();
        end
        push <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("nmea_prm_sentence_parser: match");
        end else begin
            $display("nmea_prm_sentence_parser: mismatch");
        end
        $finish;
    end

endmodule
